[sv/dee_pkg.sv]
`default_nettype none

package dee_pkg;

  // Parameter defaults
  localparam int FRAME_PIXEL_BITS_DEF    = 24;
  localparam int DISPARITY_FRAC_BITS_DEF = 5;

  // Fixed field widths
  localparam int DISP_W      = 16;
  localparam int MASK_W      = 8;
  localparam int THR_W       = 16;
  localparam int MAXD_W      = 10;
  localparam int SHIFT_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PCT_W       = 15;
  localparam int AVG_W       = 17;
  localparam int PCT_SCALE_W = 15;

  // Largest shift that scaling applies
  localparam logic [SHIFT_W-1:0] SHIFT_TOP = 2'd2;

  // Mask byte that selects a pixel
  localparam logic [MASK_W-1:0] MASK_EVAL = 8'd255;

  // 100 in Q7.8, and the ceilings of the quotients
  localparam logic [PCT_SCALE_W-1:0] PERCENT_SCALE = 15'd25600;
  localparam logic [AVG_W-1:0]       PERCENT_MAX   = 17'd25600;
  localparam logic [AVG_W-1:0]       AVERAGE_MAX   = 17'd131071;

  // Depth of the frame summary queue
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISPARITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MASK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT   = 3'd4;

  typedef struct packed {
    logic [THR_W-1:0]   bad_threshold;
    logic [MAXD_W-1:0]  max_disparity;
    logic               round_enable;
    logic               use_mask;
    logic [SHIFT_W-1:0] scale_shift;
  } dee_cfg_t;

endpackage

`default_nettype wire

[sv/disparity_error_evaluator_unit.sv]
`default_nettype none

// Channel   Handshake               Payload
// in_       in_valid / in_ready     one pixel: truth, estimate, mask, last flag
// out_      out_valid / out_ready   one frame result: counts, error sum, ratios
// cfg_      cfg_write_en            cfg_index selects the register, cfg_data
//
// The front takes one pixel per cycle unless stalled, registers it, and then updates
// the frame totals. After the last pixel of a frame the back runs five restoring
// divisions in one shared divider; a zero divisor skips the division steps.
// A two-entry queue holds frame summaries; the front stalls only when a last pixel
// meets a full queue. Reset is synchronous and clears totals, queue and sequencer.

module disparity_error_evaluator_unit #(
  parameter int FRAME_PIXEL_BITS    = dee_pkg::FRAME_PIXEL_BITS_DEF,
  parameter int DISPARITY_FRAC_BITS = dee_pkg::DISPARITY_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_en,
  input  wire logic [dee_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dee_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dee_pkg::DISP_W-1:0]     in_truth_disparity,
  input  wire logic                           in_truth_known,
  input  wire logic [dee_pkg::DISP_W-1:0]     in_estimate_disparity,
  input  wire logic                           in_estimate_valid,
  input  wire logic [dee_pkg::MASK_W-1:0]     in_mask_value,
  input  wire logic                           in_last_pixel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [FRAME_PIXEL_BITS:0]           out_pixels_evaluated,
  output logic [FRAME_PIXEL_BITS:0]           out_bad_count,
  output logic [FRAME_PIXEL_BITS:0]           out_hole_count,
  output logic [FRAME_PIXEL_BITS+16:0]        out_error_sum,
  output logic [dee_pkg::PCT_W-1:0]           out_bad_percent,
  output logic [dee_pkg::PCT_W-1:0]           out_hole_percent,
  output logic [dee_pkg::PCT_W-1:0]           out_total_bad_percent,
  output logic [dee_pkg::AVG_W-1:0]           out_average_error,
  output logic [dee_pkg::PCT_W-1:0]           out_coverage_percent,
  output logic                                out_divide_guard
);
  import dee_pkg::*;

  localparam int SUM_PACK_W = 4 * (FRAME_PIXEL_BITS + 1) + FRAME_PIXEL_BITS + 17;

  dee_cfg_t              cfg_r;
  logic                  q_push;
  logic [SUM_PACK_W-1:0] q_wdata;
  logic                  q_full;
  logic                  q_pop;
  logic [SUM_PACK_W-1:0] q_rdata;
  logic                  q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bad_threshold <= THR_W'(32);
      cfg_r.max_disparity <= MAXD_W'(255);
      cfg_r.round_enable  <= 1'b0;
      cfg_r.use_mask      <= 1'b0;
      cfg_r.scale_shift   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BAD_THRESHOLD: cfg_r.bad_threshold <= cfg_data[THR_W-1:0];
        CFG_MAX_DISPARITY: cfg_r.max_disparity <= cfg_data[MAXD_W-1:0];
        CFG_ROUND_ENABLE:  cfg_r.round_enable  <= cfg_data[0];
        CFG_USE_MASK:      cfg_r.use_mask      <= cfg_data[0];
        CFG_SCALE_SHIFT:   cfg_r.scale_shift   <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dee_front #(
    .FRAME_PIXEL_BITS    (FRAME_PIXEL_BITS),
    .DISPARITY_FRAC_BITS (DISPARITY_FRAC_BITS)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_truth_disparity    (in_truth_disparity),
    .in_truth_known        (in_truth_known),
    .in_estimate_disparity (in_estimate_disparity),
    .in_estimate_valid     (in_estimate_valid),
    .in_mask_value         (in_mask_value),
    .in_last_pixel         (in_last_pixel),
    .q_push                (q_push),
    .q_wdata               (q_wdata),
    .q_full                (q_full)
  );

  dee_queue #(
    .WIDTH (SUM_PACK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dee_back #(
    .FRAME_PIXEL_BITS (FRAME_PIXEL_BITS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_rdata               (q_rdata),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_pixels_evaluated  (out_pixels_evaluated),
    .out_bad_count         (out_bad_count),
    .out_hole_count        (out_hole_count),
    .out_error_sum         (out_error_sum),
    .out_bad_percent       (out_bad_percent),
    .out_hole_percent      (out_hole_percent),
    .out_total_bad_percent (out_total_bad_percent),
    .out_average_error     (out_average_error),
    .out_coverage_percent  (out_coverage_percent),
    .out_divide_guard      (out_divide_guard)
  );

endmodule

`default_nettype wire

[sv/dee_front.sv]
`default_nettype none

module dee_front #(
  parameter int FRAME_PIXEL_BITS    = dee_pkg::FRAME_PIXEL_BITS_DEF,
  parameter int DISPARITY_FRAC_BITS = dee_pkg::DISPARITY_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dee_pkg::dee_cfg_t          cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [dee_pkg::DISP_W-1:0] in_truth_disparity,
  input  wire logic                       in_truth_known,
  input  wire logic [dee_pkg::DISP_W-1:0] in_estimate_disparity,
  input  wire logic                       in_estimate_valid,
  input  wire logic [dee_pkg::MASK_W-1:0] in_mask_value,
  input  wire logic                       in_last_pixel,
  output logic                            q_push,
  output logic [4*(FRAME_PIXEL_BITS+1)+FRAME_PIXEL_BITS+16:0] q_wdata,
  input  wire logic                       q_full
);
  import dee_pkg::*;

  localparam int CW   = FRAME_PIXEL_BITS + 1;
  localparam int SW   = FRAME_PIXEL_BITS + 17;
  localparam int SH_W = DISP_W + 2;
  localparam int MX_W = MAXD_W + 2 + DISPARITY_FRAC_BITS;
  localparam int D_W  = ((SH_W > MX_W) ? SH_W : MX_W) + 1;

  // Classification stage
  logic [SHIFT_W-1:0] shift;
  logic [D_W-1:0]     est_sh;
  logic [D_W-1:0]     max_sh;
  logic [D_W-1:0]     clip;
  logic [D_W-1:0]     one;
  logic [D_W-1:0]     rounded;
  logic [D_W-1:0]     est_d;
  logic [D_W-1:0]     truth_d;
  logic [D_W-1:0]     err;
  logic               eval_px;
  logic               in_fire;

  logic               s1_valid_r;
  logic               s1_last_r;
  logic               s1_eval_r;
  logic               s1_good_r;
  logic               s1_hole_r;
  logic [D_W-1:0]     s1_err_r;
  logic               s1_fire;

  // Accumulators
  logic [CW-1:0]      ft_r, ft_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      bad_r, bad_nxt;
  logic [CW-1:0]      hole_r, hole_nxt;
  logic [SW-1:0]      sum_r, sum_nxt;
  logic [SW:0]        sum_wide;
  logic               is_bad;

  // Scale, clip, round and take the absolute error
  always_comb begin
    shift   = (cfg.scale_shift > SHIFT_TOP) ? SHIFT_TOP : cfg.scale_shift;
    est_sh  = D_W'(in_estimate_disparity) << shift;
    max_sh  = (D_W'(cfg.max_disparity) << shift) << DISPARITY_FRAC_BITS;
    clip    = (est_sh > max_sh) ? max_sh : est_sh;
    one     = D_W'(1) << DISPARITY_FRAC_BITS;
    rounded = (clip + (one >> 1)) & ~(one - D_W'(1));
    est_d   = cfg.round_enable ? rounded : clip;
    truth_d = D_W'(in_truth_disparity);
    err     = (est_d > truth_d) ? (est_d - truth_d) : (truth_d - est_d);
    eval_px = in_truth_known && !(cfg.use_mask && (in_mask_value != MASK_EVAL));
  end

  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && !(s1_last_r && q_full);
  assign in_ready = !s1_valid_r || s1_fire;

  // Hold the classified pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= in_last_pixel;
      s1_eval_r <= eval_px;
      s1_good_r <= eval_px && in_estimate_valid;
      s1_hole_r <= eval_px && !in_estimate_valid;
      s1_err_r  <= err;
    end
  end

  // Saturating updates of the frame totals
  always_comb begin
    is_bad   = s1_err_r > D_W'(cfg.bad_threshold);
    ft_nxt   = (&ft_r) ? ft_r : ft_r + CW'(1);
    n_nxt    = (s1_eval_r && !(&n_r)) ? n_r + CW'(1) : n_r;
    hole_nxt = (s1_hole_r && !(&hole_r)) ? hole_r + CW'(1) : hole_r;
    bad_nxt  = (s1_good_r && is_bad && !(&bad_r)) ? bad_r + CW'(1) : bad_r;
    sum_wide = {1'b0, sum_r} + (SW+1)'(s1_err_r);
    if (!s1_good_r) begin
      sum_nxt = sum_r;
    end else if (sum_wide[SW]) begin
      sum_nxt = '1;
    end else begin
      sum_nxt = sum_wide[SW-1:0];
    end
  end

  // Advance the totals, clear them after the last pixel of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ft_r   <= '0;
      n_r    <= '0;
      bad_r  <= '0;
      hole_r <= '0;
      sum_r  <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        ft_r   <= '0;
        n_r    <= '0;
        bad_r  <= '0;
        hole_r <= '0;
        sum_r  <= '0;
      end else begin
        ft_r   <= ft_nxt;
        n_r    <= n_nxt;
        bad_r  <= bad_nxt;
        hole_r <= hole_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  // Send the frame summary to the back part
  assign q_push  = s1_fire && s1_last_r;
  assign q_wdata = {ft_nxt, n_nxt, bad_nxt, hole_nxt, sum_nxt};

  a_hole_le_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (hole_r <= n_r) && (bad_r <= n_r))
    else $error("hole or bad total exceeds evaluated total");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (ft_r == '0) && (n_r == '0) && (sum_r == '0))
    else $error("totals not cleared after frame end");

endmodule

`default_nettype wire

[sv/dee_queue.sv]
`default_nettype none

module dee_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dee_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[sv/dee_back.sv]
`default_nettype none

module dee_back #(
  parameter int FRAME_PIXEL_BITS = dee_pkg::FRAME_PIXEL_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [4*(FRAME_PIXEL_BITS+1)+FRAME_PIXEL_BITS+16:0] q_rdata,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [FRAME_PIXEL_BITS:0]        out_pixels_evaluated,
  output logic [FRAME_PIXEL_BITS:0]        out_bad_count,
  output logic [FRAME_PIXEL_BITS:0]        out_hole_count,
  output logic [FRAME_PIXEL_BITS+16:0]     out_error_sum,
  output logic [dee_pkg::PCT_W-1:0]        out_bad_percent,
  output logic [dee_pkg::PCT_W-1:0]        out_hole_percent,
  output logic [dee_pkg::PCT_W-1:0]        out_total_bad_percent,
  output logic [dee_pkg::AVG_W-1:0]        out_average_error,
  output logic [dee_pkg::PCT_W-1:0]        out_coverage_percent,
  output logic                             out_divide_guard
);
  import dee_pkg::*;

  localparam int CW    = FRAME_PIXEL_BITS + 1;
  localparam int SW    = FRAME_PIXEL_BITS + 17;
  localparam int NUM_W = SW;
  localparam int PRD_W = CW + PCT_SCALE_W;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int N_DIV = 5;

  // Sequencer states
  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_LOAD  = 3'd1;
  localparam logic [2:0] B_DIV   = 3'd2;
  localparam logic [2:0] B_STORE = 3'd3;
  localparam logic [2:0] B_DONE  = 3'd4;

  // Quotient slots
  localparam logic [2:0] IX_BAD  = 3'd0;
  localparam logic [2:0] IX_HOLE = 3'd1;
  localparam logic [2:0] IX_BOTH = 3'd2;
  localparam logic [2:0] IX_AVG  = 3'd3;
  localparam logic [2:0] IX_COV  = 3'd4;

  logic [CW-1:0]    h_ft, h_n, h_bad, h_hole;
  logic [SW-1:0]    h_sum;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             guard_r, guard_nxt;

  logic [CW-1:0]    both_r;
  logic [CW-1:0]    nv_r;
  logic [CW-1:0]    den_r;
  logic [CW-1:0]    rem_r;
  logic [NUM_W-1:0] num_r;
  logic [AVG_W-1:0] res_r [N_DIV];

  logic [CW:0]      both_wide;
  logic [CW-1:0]    cnt_sel;
  logic [CW-1:0]    den_sel;
  logic [PRD_W-1:0] prod;
  logic [NUM_W-1:0] num_sel;
  logic [CW:0]      trial;
  logic             trial_ge;
  logic [CW:0]      trial_diff;
  logic [AVG_W-1:0] limit;
  logic [AVG_W-1:0] res_sat;
  logic             out_load;
  logic             out_valid_r;

  assign {h_ft, h_n, h_bad, h_hole, h_sum} = q_rdata;
  assign both_wide = {1'b0, h_bad} + {1'b0, h_hole};

  // Pick numerator and divisor of the current quotient
  always_comb begin
    case (idx_r)
      IX_BAD:  begin cnt_sel = h_bad;  den_sel = h_n;  end
      IX_HOLE: begin cnt_sel = h_hole; den_sel = h_n;  end
      IX_BOTH: begin cnt_sel = both_r; den_sel = h_n;  end
      IX_AVG:  begin cnt_sel = h_n;    den_sel = nv_r; end
      IX_COV:  begin cnt_sel = h_n;    den_sel = h_ft; end
      default: begin cnt_sel = h_n;    den_sel = h_ft; end
    endcase
    prod    = PRD_W'(cnt_sel) * PRD_W'(PERCENT_SCALE);
    num_sel = (idx_r == IX_AVG) ? h_sum : NUM_W'(prod);
  end

  // One restoring step per cycle, quotient bits shift in behind the dividend; results clip to their ceiling
  always_comb begin
    trial      = {rem_r, num_r[NUM_W-1]};
    trial_ge   = trial >= {1'b0, den_r};
    trial_diff = trial - {1'b0, den_r};
    limit      = (idx_r == IX_AVG) ? AVERAGE_MAX : PERCENT_MAX;
    res_sat    = (num_r > NUM_W'(limit)) ? limit : num_r[AVG_W-1:0];
  end

  assign out_load = (state_r == B_DONE) && (!out_valid_r || out_ready);
  assign q_pop    = out_load;

  // Sequence the five divisions of a frame
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    guard_nxt = guard_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          idx_nxt   = IX_BAD;
          guard_nxt = 1'b0;
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        if (den_sel == '0) begin
          guard_nxt = 1'b1;
          state_nxt = B_STORE;
        end else begin
          cnt_nxt   = CNT_W'(NUM_W);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = B_STORE;
        end
      end
      B_STORE: begin
        if (idx_r == IX_COV) begin
          state_nxt = B_DONE;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = B_LOAD;
        end
      end
      B_DONE: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= IX_BAD;
      cnt_r   <= '0;
      guard_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      guard_r <= guard_nxt;
    end
  end

  // Datapath of the shared divider
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        both_r <= (both_wide > {1'b0, h_n}) ? h_n : both_wide[CW-1:0];
        nv_r   <= h_n - h_hole;
      end
      B_LOAD: begin
        den_r <= den_sel;
        rem_r <= '0;
        num_r <= (den_sel == '0) ? '0 : num_sel;
      end
      B_DIV: begin
        rem_r <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
        num_r <= {num_r[NUM_W-2:0], trial_ge};
      end
      B_STORE: begin
        res_r[idx_r] <= res_sat;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixels_evaluated  <= h_n;
      out_bad_count         <= h_bad;
      out_hole_count        <= h_hole;
      out_error_sum         <= h_sum;
      out_bad_percent       <= res_r[IX_BAD][PCT_W-1:0];
      out_hole_percent      <= res_r[IX_HOLE][PCT_W-1:0];
      out_total_bad_percent <= res_r[IX_BOTH][PCT_W-1:0];
      out_average_error     <= res_r[IX_AVG];
      out_coverage_percent  <= res_r[IX_COV][PCT_W-1:0];
      out_divide_guard      <= guard_r;
    end
  end

  assign out_valid = out_valid_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (den_r != '0))
    else $error("division started with zero divisor");

  a_guard_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_pixels_evaluated == '0)) |-> out_divide_guard)
    else $error("empty frame without divide guard");

  a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bad_percent <= PCT_W'(PERCENT_MAX))
                 && (out_total_bad_percent <= PCT_W'(PERCENT_MAX))
                 && (out_coverage_percent <= PCT_W'(PERCENT_MAX)))
    else $error("percentage above ceiling");

endmodule

`default_nettype wire

[test/tb_disparity_error_evaluator_unit.sv]
`timescale 1ns / 1ps

module tb_disparity_error_evaluator_unit;
  import dee_pkg::*;

  localparam int FPB            = FRAME_PIXEL_BITS_DEF;
  localparam int FRAC           = DISPARITY_FRAC_BITS_DEF;
  localparam int CNT_W          = FPB + 1;
  localparam int SUM_W          = FPB + 17;
  localparam int LATENCY_CYCLES = 5 * (FPB + 19) + 2;
  localparam int SETTLE_CYCLES  = LATENCY_CYCLES + 50;
  localparam int CYCLE_LIMIT    = 3000000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_PIXELS   = 135;

  typedef struct packed {
    logic [DISP_W-1:0] truth;
    logic              known;
    logic [DISP_W-1:0] est;
    logic              valid;
    logic [MASK_W-1:0] mask;
    logic              last;
  } pixel_t;

  typedef struct packed {
    logic [CNT_W-1:0] evaluated;
    logic [CNT_W-1:0] bad;
    logic [CNT_W-1:0] holes;
    logic [SUM_W-1:0] err_sum;
    logic [PCT_W-1:0] bad_pct;
    logic [PCT_W-1:0] hole_pct;
    logic [PCT_W-1:0] total_bad_pct;
    logic [AVG_W-1:0] avg_err;
    logic [PCT_W-1:0] coverage_pct;
    logic             guard;
  } frame_stats_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_NEVER, READY_COIN} ready_mode_t;

  // Frame statistics predictor: per-pixel totals and the expected frame results
  class frame_stats_tracker;
    dee_cfg_t         regs;
    logic [CNT_W-1:0] evaluated;
    logic [CNT_W-1:0] bad;
    logic [CNT_W-1:0] holes;
    logic [CNT_W-1:0] streamed;
    logic [SUM_W-1:0] err_sum;
    frame_stats_t     expected_q[$];
    int               mismatches;

    function new();
      regs.bad_threshold = 16'd32;
      regs.max_disparity = 10'd255;
      regs.round_enable  = 1'b0;
      regs.use_mask      = 1'b0;
      regs.scale_shift   = 2'd0;
      clear_totals();
      mismatches = 0;
    endfunction

    function void clear_totals();
      evaluated = '0;
      bad       = '0;
      holes     = '0;
      streamed  = '0;
      err_sum   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BAD_THRESHOLD: regs.bad_threshold = val;
        CFG_MAX_DISPARITY: regs.max_disparity = val[MAXD_W-1:0];
        CFG_ROUND_ENABLE:  regs.round_enable  = val[0];
        CFG_USE_MASK:      regs.use_mask      = val[0];
        CFG_SCALE_SHIFT:   regs.scale_shift   = val[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // Q7.8 share of 100*num/den, truncated and clipped; flag a zero divisor
    function logic [PCT_W-1:0] share_q8(logic [CNT_W-1:0] num, logic [CNT_W-1:0] den,
                                        inout logic guard);
      longint unsigned q;
      if (den == 0) begin
        guard = 1'b1;
        return '0;
      end
      q = (64'(num) * 64'(PERCENT_SCALE)) / 64'(den);
      return (q > 64'(PERCENT_MAX)) ? PERCENT_MAX[PCT_W-1:0] : q[PCT_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_pixel(pixel_t p);
      logic [SHIFT_W-1:0] sh;
      logic [18:0]        scaled;
      logic [18:0]        ceiling;
      logic [18:0]        err;
      logic [SUM_W:0]     wide;
      logic [CNT_W:0]     both;
      logic [CNT_W-1:0]   valid_px;
      longint unsigned    q;
      frame_stats_t       st;
      sh = (regs.scale_shift > SHIFT_TOP) ? SHIFT_TOP : regs.scale_shift;
      streamed = bump(streamed);
      if (p.known && !(regs.use_mask && p.mask != MASK_EVAL)) begin
        evaluated = bump(evaluated);
        if (p.valid) begin
          // Scale, clip, round half up when enabled, then take the distance to the truth
          scaled  = 19'(p.est) << sh;
          ceiling = (19'(regs.max_disparity) << sh) << FRAC;
          if (scaled > ceiling) scaled = ceiling;
          if (regs.round_enable && FRAC > 0)
            scaled = (scaled + (19'd1 << (FRAC - 1))) & ~((19'd1 << FRAC) - 19'd1);
          err = (scaled > 19'(p.truth)) ? scaled - 19'(p.truth) : 19'(p.truth) - scaled;
          wide = (SUM_W + 1)'(err_sum) + (SUM_W + 1)'(err);
          err_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
          if (err > 19'(regs.bad_threshold)) bad = bump(bad);
        end else begin
          holes = bump(holes);
        end
      end
      if (!p.last) return;

      // Close the frame: build the summary and clear the totals
      st.guard  = 1'b0;
      both      = (CNT_W + 1)'(bad) + (CNT_W + 1)'(holes);
      if (both > (CNT_W + 1)'(evaluated)) both = (CNT_W + 1)'(evaluated);
      valid_px  = evaluated - holes;
      if (valid_px == 0) begin
        st.guard   = 1'b1;
        st.avg_err = '0;
      end else begin
        q = 64'(err_sum) / 64'(valid_px);
        st.avg_err = (q > 64'(AVERAGE_MAX)) ? AVERAGE_MAX : q[AVG_W-1:0];
      end
      st.evaluated     = evaluated;
      st.bad           = bad;
      st.holes         = holes;
      st.err_sum       = err_sum;
      st.bad_pct       = share_q8(bad, evaluated, st.guard);
      st.hole_pct      = share_q8(holes, evaluated, st.guard);
      st.total_bad_pct = share_q8(both[CNT_W-1:0], evaluated, st.guard);
      st.coverage_pct  = share_q8(evaluated, streamed, st.guard);
      expected_q.push_back(st);
      clear_totals();
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame stats mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_stats(frame_stats_t got);
      frame_stats_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame stats arrived with no frame pending: evaluated %0d", got.evaluated);
        return;
      end
      want = expected_q.pop_front();
      compare_field("pixels_evaluated", want.evaluated, got.evaluated);
      compare_field("bad_count", want.bad, got.bad);
      compare_field("hole_count", want.holes, got.holes);
      compare_field("error_sum", want.err_sum, got.err_sum);
      compare_field("bad_percent", want.bad_pct, got.bad_pct);
      compare_field("hole_percent", want.hole_pct, got.hole_pct);
      compare_field("total_bad_percent", want.total_bad_pct, got.total_bad_pct);
      compare_field("average_error", want.avg_err, got.avg_err);
      compare_field("coverage_percent", want.coverage_pct, got.coverage_pct);
      compare_field("divide_guard", want.guard, got.guard);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DISP_W-1:0]     in_truth_disparity = '0;
  logic                  in_truth_known = 1'b0;
  logic [DISP_W-1:0]     in_estimate_disparity = '0;
  logic                  in_estimate_valid = 1'b0;
  logic [MASK_W-1:0]     in_mask_value = '0;
  logic                  in_last_pixel = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CNT_W-1:0]      out_pixels_evaluated;
  logic [CNT_W-1:0]      out_bad_count;
  logic [CNT_W-1:0]      out_hole_count;
  logic [SUM_W-1:0]      out_error_sum;
  logic [PCT_W-1:0]      out_bad_percent;
  logic [PCT_W-1:0]      out_hole_percent;
  logic [PCT_W-1:0]      out_total_bad_percent;
  logic [AVG_W-1:0]      out_average_error;
  logic [PCT_W-1:0]      out_coverage_percent;
  logic                  out_divide_guard;

  frame_stats_tracker tracker = new();
  int                 cycle_count = 0;
  int                 burst_left = 0;
  ready_mode_t        ready_mode = READY_ALWAYS;
  int                 ready_left = 0;

  disparity_error_evaluator_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_truth_disparity   (in_truth_disparity),
    .in_truth_known       (in_truth_known),
    .in_estimate_disparity(in_estimate_disparity),
    .in_estimate_valid    (in_estimate_valid),
    .in_mask_value        (in_mask_value),
    .in_last_pixel        (in_last_pixel),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pixels_evaluated (out_pixels_evaluated),
    .out_bad_count        (out_bad_count),
    .out_hole_count       (out_hole_count),
    .out_error_sum        (out_error_sum),
    .out_bad_percent      (out_bad_percent),
    .out_hole_percent     (out_hole_percent),
    .out_total_bad_percent(out_total_bad_percent),
    .out_average_error    (out_average_error),
    .out_coverage_percent (out_coverage_percent),
    .out_divide_guard     (out_divide_guard)
  );

  always #4 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_disparity_error_evaluator_unit: FAIL");
      $finish;
    end
  end

  // Record each accepted pixel request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      tracker.note_pixel({in_truth_disparity, in_truth_known, in_estimate_disparity,
                          in_estimate_valid, in_mask_value, in_last_pixel});
  end

  // Check each accepted frame result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_stats({out_pixels_evaluated, out_bad_count, out_hole_count,
                           out_error_sum, out_bad_percent, out_hole_percent,
                           out_total_bad_percent, out_average_error,
                           out_coverage_percent, out_divide_guard});
  end

  // Stall the result side in segments: open, closed, or coin toss per cycle
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      case (ready_mode)
        READY_ALWAYS: ready_left = $urandom_range(1, 300);
        READY_NEVER:  ready_left = $urandom_range(1, 200);
        default:      ready_left = $urandom_range(1, 300);
      endcase
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_NEVER:  out_ready <= 1'b0;
      default:      out_ready <= $urandom_range(0, 1);
    endcase
  end

  function automatic pixel_t make_pixel(int truth, bit known, int est, bit valid, int mask,
                                        bit last);
    pixel_t p;
    p.truth = truth[DISP_W-1:0];
    p.known = known;
    p.est   = est[DISP_W-1:0];
    p.valid = valid;
    p.mask  = mask[MASK_W-1:0];
    p.last  = last;
    return p;
  endfunction

  // Mostly estimates close to the scaled-down truth, some arbitrary ones
  function automatic pixel_t random_pixel(bit last);
    int truth;
    int est;
    int sh;
    int mask;
    sh    = (tracker.regs.scale_shift > SHIFT_TOP) ? int'(SHIFT_TOP)
                                                   : int'(tracker.regs.scale_shift);
    truth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 9000);
    if ($urandom_range(0, 4) < 3) begin
      est = (truth >> sh) + $urandom_range(0, 96) - 48;
      if (est < 0) est = 0;
      if (est > 65535) est = 65535;
    end else begin
      est = $urandom_range(0, 65535);
    end
    mask = ($urandom_range(0, 9) < 7) ? 255 : $urandom_range(0, 255);
    return make_pixel(truth, $urandom_range(0, 7) != 0, est, $urandom_range(0, 7) != 0,
                      mask, last);
  endfunction

  task automatic send_pixel(pixel_t p);
    @(negedge clk);
    in_valid              <= 1'b1;
    in_truth_disparity    <= p.truth;
    in_truth_known        <= p.known;
    in_estimate_disparity <= p.est;
    in_estimate_valid     <= p.valid;
    in_mask_value         <= p.mask;
    in_last_pixel         <= p.last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Hold off until every pending frame result has come out
  task automatic wait_results_drained();
    pause_sender(1);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Work in bursts; a long burst now and then gives stretches with no gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_sender($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val[CFG_DATA_W-1:0];
    tracker.write_reg(idx, val[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic write_all_regs(int thr, int maxd, int rnd, int msk, int sh);
    write_reg(CFG_BAD_THRESHOLD, thr);
    write_reg(CFG_MAX_DISPARITY, maxd);
    write_reg(CFG_ROUND_ENABLE, rnd);
    write_reg(CFG_USE_MASK, msk);
    write_reg(CFG_SCALE_SHIFT, sh);
  endtask

  // Random phases start at the extremes, then mix small and full-range values
  task automatic apply_phase_config(int ph);
    int thr;
    int maxd;
    int sh;
    case (ph)
      0: write_all_regs(0, 0, 0, 0, 0);
      1: write_all_regs(65535, 1023, 1, 1, 3);
      default: begin
        thr  = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
        maxd = $urandom_range(0, 1) ? 1023 : $urandom_range(0, 1023);
        sh   = (ph == 2) ? 1 : (ph == 3) ? 2 : $urandom_range(0, 3);
        write_all_regs(thr, maxd, $urandom_range(0, 1), $urandom_range(0, 1), sh);
      end
    endcase
  endtask

  initial begin
    int sent;
    int frame_len;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: frame with nothing evaluated, frame with only a hole
    send_pixel(make_pixel(100, 0, 3, 1, 255, 1));
    send_pixel(make_pixel(100, 1, 3, 0, 255, 1));
    // Field extremes, clipping, and errors on both sides of the threshold
    send_pixel(make_pixel(0, 1, 0, 1, 255, 0));
    send_pixel(make_pixel(65535, 1, 0, 1, 255, 0));
    send_pixel(make_pixel(0, 1, 65535, 1, 255, 0));
    send_pixel(make_pixel(65535, 1, 65535, 1, 0, 0));
    send_pixel(make_pixel(0, 1, 33, 1, 17, 0));
    send_pixel(make_pixel(0, 1, 32, 1, 255, 0));
    send_pixel(make_pixel(0, 0, 0, 0, 0, 1));
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Mask on, shift of three (applied as two), rounding, zero threshold
    write_all_regs(0, 1023, 1, 1, 3);
    send_pixel(make_pixel(100, 1, 16, 1, 255, 0));
    send_pixel(make_pixel(100, 1, 16, 1, 254, 0));
    send_pixel(make_pixel(100, 1, 16, 1, 0, 0));
    send_pixel(make_pixel(0, 1, 65535, 1, 255, 0));
    send_pixel(make_pixel(32, 1, 4, 1, 255, 0));
    send_pixel(make_pixel(0, 1, 3, 1, 255, 0));
    send_pixel(make_pixel(50, 1, 9, 0, 255, 0));
    send_pixel(make_pixel(50, 0, 9, 1, 255, 1));
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Random frames, mostly short, now and then a long one
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_phase_config(ph);
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
                                                : $urandom_range(1, 30);
        for (int i = 0; i < frame_len; i++) begin
          send_pixel(random_pixel(i == frame_len - 1));
          sent++;
          pace_sender();
        end
        if ($urandom_range(0, 11) == 0) wait_results_drained();
      end
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clk);
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_disparity_error_evaluator_unit: PASS");
    end else begin
      $display("tb_disparity_error_evaluator_unit: FAIL");
    end
    $finish;
  end

endmodule

[disparity_error_evaluator_unit.f]
sv/dee_pkg.sv
sv/dee_front.sv
sv/dee_queue.sv
sv/dee_back.sv
sv/disparity_error_evaluator_unit.sv
test/tb_disparity_error_evaluator_unit.sv
